FILE: design/trd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package trd_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int YW         = $clog2(MAX_HEIGHT);
    localparam int AW         = XW + YW;
    localparam int QDEPTH     = 4;
    localparam int QPW        = $clog2(QDEPTH);

    localparam logic       CFG_FRAME_WIDTH  = 1'b0;
    localparam logic       CFG_FRAME_HEIGHT = 1'b1;
    localparam logic       MODE_LOAD        = 1'b0;
    localparam logic       MODE_STEP        = 1'b1;
    localparam logic [15:0] DEPTH_MIN       = 16'h8000;
    localparam logic [16:0] WEIGHT_ONE      = 17'd32768;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] vertex_a_x;
        logic signed [15:0] vertex_a_y;
        logic signed [15:0] vertex_a_depth;
        logic signed [15:0] vertex_b_x;
        logic signed [15:0] vertex_b_y;
        logic signed [15:0] vertex_b_depth;
        logic signed [15:0] vertex_c_x;
        logic signed [15:0] vertex_c_y;
        logic signed [15:0] vertex_c_depth;
    } item_t;

    typedef struct packed {
        logic [7:0]         pixel_x;
        logic [7:0]         pixel_y;
        logic               visible;
        logic [15:0]        weight_a;
        logic [15:0]        weight_b;
        logic [15:0]        weight_c;
        logic signed [15:0] fragment_depth;
        logic               last_pixel;
    } result_t;

    // one pixel job handed from front to back
    typedef struct packed {
        logic               active;
        logic               last;
        logic [XW-1:0]      x;
        logic [YW-1:0]      y;
        logic signed [15:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    } job_t;

    typedef enum logic [2:0] {
        B_CLEAR, B_IDLE, B_MUL, B_CLASS, B_DIVB, B_DIVC, B_ZMUL, B_CMP
    } back_state_t;

endpackage
`default_nettype wire

FILE: design/trd_front.sv
`timescale 1ns / 1ps
`default_nettype none
module trd_front import trd_pkg::*; (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          take,
    input  wire item_t         item,
    input  wire logic          cfg_we,
    input  wire logic          cfg_index,
    input  wire logic [8:0]    cfg_data,
    output job_t               job,
    output logic               push
);
    logic [8:0] fw_reg, fh_reg;
    logic [XW-1:0] cx_reg, x0_reg, x1_reg;
    logic [YW-1:0] cy_reg, y0_reg, y1_reg;
    logic active_reg;
    logic signed [15:0] v_reg [9];
    logic signed [15:0] v_next [9];

    logic [12:0] w_lim, h_lim;
    logic signed [15:0] lox, hix, loy, hiy;
    logic signed [12:0] fx0, fx1, fy0, fy1;
    logic signed [13:0] sx0, sx1, sy0, sy1;
    logic ld_active;
    logic last_c;

    assign v_next = '{item.vertex_a_x, item.vertex_a_y, item.vertex_a_depth,
                      item.vertex_b_x, item.vertex_b_y, item.vertex_b_depth,
                      item.vertex_c_x, item.vertex_c_y, item.vertex_c_depth};

    always_comb
    begin
        w_lim = (fw_reg == 9'd0) ? 13'd1 :
                (fw_reg > 9'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(fw_reg);
        h_lim = (fh_reg == 9'd0) ? 13'd1 :
                (fh_reg > 9'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : 13'(fh_reg);
        lox = item.vertex_a_x; hix = item.vertex_a_x;
        loy = item.vertex_a_y; hiy = item.vertex_a_y;
        if (item.vertex_b_x < lox) lox = item.vertex_b_x;
        if (item.vertex_c_x < lox) lox = item.vertex_c_x;
        if (item.vertex_b_x > hix) hix = item.vertex_b_x;
        if (item.vertex_c_x > hix) hix = item.vertex_c_x;
        if (item.vertex_b_y < loy) loy = item.vertex_b_y;
        if (item.vertex_c_y < loy) loy = item.vertex_c_y;
        if (item.vertex_b_y > hiy) hiy = item.vertex_b_y;
        if (item.vertex_c_y > hiy) hiy = item.vertex_c_y;
        fx0 = 13'(lox >>> 4);
        fy0 = 13'(loy >>> 4);
        fx1 = 13'((17'(hix) + 17'sd15) >>> 4);
        fy1 = 13'((17'(hiy) + 17'sd15) >>> 4);
        sx0 = (fx0 < 0) ? 14'sd0 : 14'(fx0);
        sy0 = (fy0 < 0) ? 14'sd0 : 14'(fy0);
        sx1 = (14'(fx1) > $signed({1'b0, w_lim}) - 14'sd1)
              ? $signed({1'b0, w_lim}) - 14'sd1 : 14'(fx1);
        sy1 = (14'(fy1) > $signed({1'b0, h_lim}) - 14'sd1)
              ? $signed({1'b0, h_lim}) - 14'sd1 : 14'(fy1);
        ld_active = (sx0 <= sx1) && (sy0 <= sy1);
        last_c = (cy_reg >= y1_reg) && (cx_reg >= x1_reg);
    end

    assign push = take && (item.mode == MODE_STEP);

    always_comb
    begin
        job.active = active_reg;
        job.last   = last_c || !active_reg;
        job.x = cx_reg;  job.y = cy_reg;
        job.ax = v_reg[0]; job.ay = v_reg[1]; job.az = v_reg[2];
        job.bx = v_reg[3]; job.by = v_reg[4]; job.bz = v_reg[5];
        job.cx = v_reg[6]; job.cy = v_reg[7]; job.cz = v_reg[8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= 9'(MAX_WIDTH);
            fh_reg <= 9'(MAX_HEIGHT);
            cx_reg <= '0; cy_reg <= '0;
            x0_reg <= '0; x1_reg <= '0; y0_reg <= '0; y1_reg <= '0;
            active_reg <= 1'b0;
            for (int i = 0; i < 9; i++) v_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_FRAME_WIDTH) fw_reg <= cfg_data;
                else fh_reg <= cfg_data;
            end
            if (take && item.mode == MODE_LOAD)
            begin
                v_reg <= v_next;
                x0_reg <= XW'(sx0); x1_reg <= XW'(sx1);
                y0_reg <= YW'(sy0); y1_reg <= YW'(sy1);
                cx_reg <= XW'(sx0); cy_reg <= YW'(sy0);
                active_reg <= ld_active;
            end
            else if (push && active_reg)
            begin
                if (cy_reg >= y1_reg)
                begin
                    cy_reg <= y0_reg;
                    if (cx_reg >= x1_reg) active_reg <= 1'b0;
                    else cx_reg <= cx_reg + 1'b1;
                end
                else
                    cy_reg <= cy_reg + 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

FILE: design/trd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module trd_queue import trd_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire job_t   din,
    input  wire logic   pop,
    output job_t        dout,
    output logic        empty,
    output logic        full
);
    job_t slot_reg [QDEPTH];
    logic [QPW-1:0] wp_reg, rp_reg;
    logic [QPW:0] cnt_reg;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == (QPW+1)'(QDEPTH));
    assign dout  = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push) slot_reg[wp_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QPW+1)'(push) - (QPW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

FILE: design/trd_back.sv
`timescale 1ns / 1ps
`default_nettype none
module trd_back import trd_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire job_t   job_in,
    input  wire logic   avail,
    output logic        pop,
    output logic        clearing,
    output logic        done,
    output result_t     result
);
    back_state_t state_reg, state_next;
    job_t job_reg;
    logic [2:0] mcnt_reg;
    logic [4:0] dcnt_reg;
    logic [1:0] zcnt_reg;
    logic [AW:0] clr_reg;
    logic signed [35:0] prod_reg [6];
    logic [36:0] rem_reg, den_reg;
    logic [15:0] q_reg, wb_reg, wc_reg, wa_reg;
    logic signed [35:0] acc_reg;
    logic [15:0] mem [MAX_WIDTH*MAX_HEIGHT];
    logic [15:0] rd_reg;
    logic done_reg;
    result_t res_reg;
    logic [36:0] nc_reg_hold;

    logic signed [17:0] ma, mb, ex, ey;
    logic signed [35:0] mp;
    logic signed [37:0] area, nb, nc, na;
    logic [36:0] area_m, nb_m, nc_m, rsh;
    logic [15:0] qnext;
    logic pass;
    logic signed [15:0] zv, depth;
    logic [15:0] wv;
    logic signed [35:0] racc;
    logic [AW-1:0] addr;

    assign addr = {job_reg.y, job_reg.x};
    assign ex = 18'(job_reg.ax) - 18'($signed({1'b0, job_reg.x, 4'b0}));
    assign ey = 18'(job_reg.ay) - 18'($signed({1'b0, job_reg.y, 4'b0}));

    always_comb
    begin
        case (mcnt_reg)
            3'd0: begin ma = 18'(job_reg.bx) - 18'(job_reg.ax); mb = 18'(job_reg.cy) - 18'(job_reg.ay); end
            3'd1: begin ma = 18'(job_reg.cx) - 18'(job_reg.ax); mb = 18'(job_reg.by) - 18'(job_reg.ay); end
            3'd2: begin ma = 18'(job_reg.cx) - 18'(job_reg.ax); mb = ey; end
            3'd3: begin ma = ex; mb = 18'(job_reg.cy) - 18'(job_reg.ay); end
            3'd4: begin ma = ex; mb = 18'(job_reg.by) - 18'(job_reg.ay); end
            default: begin ma = 18'(job_reg.bx) - 18'(job_reg.ax); mb = ey; end
        endcase
        mp = ma * mb;
        area = 38'(prod_reg[0]) - 38'(prod_reg[1]);
        nb   = 38'(prod_reg[2]) - 38'(prod_reg[3]);
        nc   = 38'(prod_reg[4]) - 38'(prod_reg[5]);
        na   = area - nb - nc;
        area_m = 37'(area[37] ? -area : area);
        nb_m   = 37'(nb[37] ? -nb : nb);
        nc_m   = 37'(nc[37] ? -nc : nc);
        // inside: |area|>=256, no weight of other sign
        pass = (area_m >= 37'd256)
            && !((na != 0) && (na[37] != area[37]))
            && !((nb != 0) && (nb[37] != area[37]))
            && !((nc != 0) && (nc[37] != area[37]));
        rsh = (dcnt_reg == 5'd0) ? rem_reg : {rem_reg[35:0], 1'b0};
        qnext = {q_reg[14:0], rsh >= den_reg};
        case (zcnt_reg)
            2'd0:    begin zv = job_reg.az; wv = wa_reg; end
            2'd1:    begin zv = job_reg.bz; wv = wb_reg; end
            default: begin zv = job_reg.cz; wv = wc_reg; end
        endcase
        racc = acc_reg + 36'sd16384;
        depth = 16'(racc >>> 15);
    end

    always_comb
    begin
        state_next = state_reg;
        pop = 1'b0;
        unique case (state_reg)
            B_CLEAR: if (clr_reg == (AW+1)'(MAX_WIDTH*MAX_HEIGHT - 1)) state_next = B_IDLE;
            B_IDLE:
                if (avail)
                begin
                    pop = 1'b1;
                    if (job_in.active) state_next = B_MUL;
                end
            B_MUL:   if (mcnt_reg == 3'd5) state_next = B_CLASS;
            B_CLASS: state_next = pass ? B_DIVB : B_IDLE;
            B_DIVB:  if (dcnt_reg == 5'd15) state_next = B_DIVC;
            B_DIVC:  if (dcnt_reg == 5'd15) state_next = B_ZMUL;
            B_ZMUL:  if (zcnt_reg == 2'd2) state_next = B_CMP;
            B_CMP:   state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLEAR;
            clr_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_CLEAR) clr_reg <= clr_reg + 1'b1;
            done_reg <= (state_reg == B_IDLE && avail && !job_in.active)
                || (state_reg == B_CLASS && !pass) || state_reg == B_CMP;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_CLEAR) mem[clr_reg[AW-1:0]] <= DEPTH_MIN;
        else if (state_reg == B_CMP && $signed(depth) >= $signed(rd_reg))
            mem[addr] <= depth;
        rd_reg <= mem[addr];

        case (state_reg)
            B_IDLE:
            begin
                job_reg <= job_in;
                mcnt_reg <= '0;
                res_reg <= '{pixel_x: job_in.active ? 8'(job_in.x) : 8'd0,
                             pixel_y: job_in.active ? 8'(job_in.y) : 8'd0,
                             visible: 1'b0,
                             weight_a: 16'd0, weight_b: 16'd0, weight_c: 16'd0,
                             fragment_depth: 16'sd0,
                             last_pixel: job_in.last};
            end
            B_MUL:
            begin
                prod_reg[mcnt_reg] <= mp;
                mcnt_reg <= mcnt_reg + 1'b1;
            end
            B_CLASS:
            begin
                rem_reg <= nb_m; den_reg <= area_m;
                dcnt_reg <= '0; q_reg <= '0;
                nc_reg_hold <= nc_m;
            end
            B_DIVB, B_DIVC:
            begin
                if (dcnt_reg == 5'd15)
                begin
                    dcnt_reg <= '0;
                    q_reg <= '0;
                    if (state_reg == B_DIVB)
                    begin
                        wb_reg <= qnext;
                        rem_reg <= nc_reg_hold;
                    end
                    else
                    begin
                        wc_reg <= qnext;
                        wa_reg <= 16'(WEIGHT_ONE - 17'(wb_reg) - 17'(qnext));
                    end
                end
                else
                begin
                    rem_reg <= (rsh >= den_reg) ? rsh - den_reg : rsh;
                    q_reg <= qnext;
                    dcnt_reg <= dcnt_reg + 1'b1;
                end
                zcnt_reg <= '0;
                acc_reg <= '0;
            end
            B_ZMUL:
            begin
                acc_reg <= acc_reg + 36'(zv * $signed({1'b0, wv}));
                zcnt_reg <= zcnt_reg + 1'b1;
            end
            B_CMP:
            begin
                if ($signed(depth) >= $signed(rd_reg))
                begin
                    res_reg.visible <= 1'b1;
                    res_reg.weight_a <= wa_reg;
                    res_reg.weight_b <= wb_reg;
                    res_reg.weight_c <= wc_reg;
                    res_reg.fragment_depth <= depth;
                end
            end
            default: ;
        endcase
    end

    assign clearing = (state_reg == B_CLEAR);
    assign done = done_reg;
    assign result = res_reg;
endmodule
`default_nettype wire

FILE: design/triangle_raster_depth_test.sv
// channel   | handshake                 | payload
// item      | start / busy              | item (item_t)
// result    | done strobe, no stall     | result (result_t)
// config    | cfg_valid / cfg_ready     | cfg_index, cfg_data
// A step strobes done once: straight from the queue when there is no triangle,
// after the cross products when the pixel misses, and after the whole back end
// when inside: one shared 18x18 multiplier for six products, a 16-step divider
// run twice, three depth multiplies. After reset a clearing pass writes all
// 65536 depth entries, holding busy high meanwhile. A 4-entry queue lets steps
// be taken while the back works; busy is high while it is full or clearing.
`timescale 1ns / 1ps
`default_nettype none
module triangle_raster_depth_test import trd_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire item_t       item,
    output logic             done,
    output result_t          result,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [8:0]  cfg_data
);
    job_t job_f, job_q;
    logic push, pop, empty, full, clearing;

    assign busy = full || clearing;
    assign cfg_ready = 1'b1;

    trd_front u_front (
        .clk, .rst_n, .take(start && !busy), .item,
        .cfg_we(cfg_valid), .cfg_index, .cfg_data,
        .job(job_f), .push
    );

    trd_queue u_queue (
        .clk, .rst_n, .push, .din(job_f), .pop, .dout(job_q), .empty, .full
    );

    trd_back u_back (
        .clk, .rst_n, .job_in(job_q), .avail(!empty), .pop,
        .clearing, .done, .result
    );
endmodule
`default_nettype wire

FILE: design/trd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module trd_checker import trd_pkg::*; (
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    done,
    input wire result_t result,
    input wire logic    cfg_ready
);
    a_sum: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.visible |->
        (17'(result.weight_a) + 17'(result.weight_b) + 17'(result.weight_c)) == WEIGHT_ONE)
        else $error("weights do not sum to one");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.visible |-> result.weight_a == 16'd0 && result.weight_b == 16'd0
        && result.weight_c == 16'd0 && result.fragment_depth == 16'sd0)
        else $error("invisible fragment carries data");
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config port stalled");
endmodule

bind triangle_raster_depth_test trd_checker u_checker (
    .clk, .rst_n, .done, .result, .cfg_ready
);
`default_nettype wire

FILE: bench/tb_triangle_raster_depth_test.sv
`timescale 1ns / 1ps
module tb_triangle_raster_depth_test;
    import trd_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 400;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    item_t   item = '0;
    logic    done;
    result_t result;
    logic    cfg_valid = 1'b0;
    logic    cfg_ready;
    logic    cfg_index = CFG_FRAME_WIDTH;
    logic [8:0] cfg_data = '0;

    triangle_raster_depth_test dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // raster model state
    logic signed [15:0] zbuf [0:MAX_WIDTH*MAX_HEIGHT-1];
    longint  cur_x, cur_y, box_x0, box_x1, box_y0, box_y1;
    longint  vx [3], vy [3], vz [3];
    bit      tri_live;
    logic [8:0] frame_w = 9'd256, frame_h = 9'd256;

    item_t   pending_items [$];
    result_t expected_pixels [$];
    bit      no_gaps = 0;
    bit      failed = 0;
    bit      took = 0;
    int      gap = 0;
    int      cycles = 0;

    function automatic bit opposite(longint num, longint den);
        return (num < 0 && den > 0) || (num > 0 && den < 0);
    endfunction

    function automatic longint clamp_dim(logic [8:0] v, longint maxv);
        longint d;
        d = v;
        if (d < 1) d = 1;
        if (d > maxv) d = maxv;
        return d;
    endfunction

    task automatic raster_predict(input item_t it);
        longint  lo_x, hi_x, lo_y, hi_y, w, h, px, py, area, nb, nc, na, acc, dep, mag_a;
        longint  wa, wb, wc;
        int      idx;
        bit      vis, last;
        result_t r;
        if (it.mode == MODE_LOAD) begin
            vx[0] = it.vertex_a_x; vy[0] = it.vertex_a_y; vz[0] = it.vertex_a_depth;
            vx[1] = it.vertex_b_x; vy[1] = it.vertex_b_y; vz[1] = it.vertex_b_depth;
            vx[2] = it.vertex_c_x; vy[2] = it.vertex_c_y; vz[2] = it.vertex_c_depth;
            w = clamp_dim(frame_w, MAX_WIDTH);
            h = clamp_dim(frame_h, MAX_HEIGHT);
            lo_x = vx[0]; hi_x = vx[0]; lo_y = vy[0]; hi_y = vy[0];
            for (int i = 1; i < 3; i++)
            begin
                if (vx[i] < lo_x) lo_x = vx[i];
                if (vx[i] > hi_x) hi_x = vx[i];
                if (vy[i] < lo_y) lo_y = vy[i];
                if (vy[i] > hi_y) hi_y = vy[i];
            end
            box_x0 = lo_x >>> 4;
            if (box_x0 < 0) box_x0 = 0;
            box_y0 = lo_y >>> 4;
            if (box_y0 < 0) box_y0 = 0;
            box_x1 = -((-hi_x) >>> 4);
            if (box_x1 > w - 1) box_x1 = w - 1;
            box_y1 = -((-hi_y) >>> 4);
            if (box_y1 > h - 1) box_y1 = h - 1;
            cur_x = box_x0;
            cur_y = box_y0;
            tri_live = (box_x0 <= box_x1) && (box_y0 <= box_y1);
            return;
        end
        r = '0;
        if (!tri_live) begin
            r.last_pixel = 1'b1;
            expected_pixels.push_back(r);
            return;
        end
        px = cur_x * 16;
        py = cur_y * 16;
        area = (vx[1] - vx[0]) * (vy[2] - vy[0]) - (vx[2] - vx[0]) * (vy[1] - vy[0]);
        nb = (vx[2] - vx[0]) * (vy[0] - py) - (vx[0] - px) * (vy[2] - vy[0]);
        nc = (vx[0] - px) * (vy[1] - vy[0]) - (vx[1] - vx[0]) * (vy[0] - py);
        na = area - nb - nc;
        mag_a = area < 0 ? -area : area;
        vis = 0;
        wa = 0; wb = 0; wc = 0; dep = 0;
        if (mag_a >= 256 && !opposite(na, area) && !opposite(nb, area)
            && !opposite(nc, area)) begin
            wb = ((nb < 0 ? -nb : nb) * 32768) / mag_a;
            wc = ((nc < 0 ? -nc : nc) * 32768) / mag_a;
            wa = 32768 - wb - wc;
            acc = vz[0] * wa + vz[1] * wb + vz[2] * wc;
            dep = (acc + 16384) >>> 15;
            idx = int'(cur_y * MAX_WIDTH + cur_x);
            if (dep >= longint'(zbuf[idx])) begin
                zbuf[idx] = dep[15:0];
                vis = 1;
            end
        end
        r.pixel_x = cur_x[7:0];
        r.pixel_y = cur_y[7:0];
        last = 0;
        if (cur_y >= box_y1) begin
            cur_y = box_y0;
            if (cur_x >= box_x1) begin
                last = 1;
                tri_live = 0;
            end
            else
                cur_x++;
        end
        else
            cur_y++;
        if (vis) begin
            r.visible = 1'b1;
            r.weight_a = wa[15:0];
            r.weight_b = wb[15:0];
            r.weight_c = wc[15:0];
            r.fragment_depth = dep[15:0];
        end
        r.last_pixel = last;
        expected_pixels.push_back(r);
    endtask

    // driver: new values at the falling edge
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (start && !took) begin
                // held until accepted
            end
            else if (gap > 0) begin
                start <= 1'b0;
                gap <= gap - 1;
            end
            else if (pending_items.size() > 0) begin
                item <= pending_items.pop_front();
                start <= 1'b1;
                if (!no_gaps && $urandom_range(0, 7) == 0)
                    gap <= $urandom_range(1, 10);
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: sample at the rising edge
    always @(posedge clk)
    begin
        result_t want;
        cycles <= cycles + 1;
        took <= start && !busy && rst_n;
        if (rst_n && start && !busy)
            raster_predict(item);
        if (rst_n && done) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, result);
                failed = 1;
            end
            else begin
                want = expected_pixels.pop_front();
                if (result.pixel_x !== want.pixel_x || result.pixel_y !== want.pixel_y
                    || result.visible !== want.visible || result.weight_a !== want.weight_a
                    || result.weight_b !== want.weight_b || result.weight_c !== want.weight_c
                    || result.fragment_depth !== want.fragment_depth
                    || result.last_pixel !== want.last_pixel) begin
                    $display("%0t: pixel mismatch, expected %p, actual %p", $time, want, result);
                    failed = 1;
                end
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic add_load(input int ax, ay, az, bx, by, bz, cx, cy, cz);
        item_t it;
        it.mode = MODE_LOAD;
        it.vertex_a_x = 16'(ax); it.vertex_a_y = 16'(ay); it.vertex_a_depth = 16'(az);
        it.vertex_b_x = 16'(bx); it.vertex_b_y = 16'(by); it.vertex_b_depth = 16'(bz);
        it.vertex_c_x = 16'(cx); it.vertex_c_y = 16'(cy); it.vertex_c_depth = 16'(cz);
        pending_items.push_back(it);
    endtask

    task automatic add_steps(input int n);
        item_t it;
        logic [159:0] raw;
        repeat (n)
        begin
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
            it = raw[$bits(item_t)-1:0];
            it.mode = MODE_STEP;
            pending_items.push_back(it);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [8:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_FRAME_WIDTH) frame_w = val;
        else frame_h = val;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && !start);
        while (expected_pixels.size() > 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic random_triangles(input int budget);
        int base_x, base_y, n;
        while (n < budget)
        begin
            if ($urandom_range(0, 99) < 15)
                add_load($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom);
            else begin
                base_x = int'($urandom_range(0, 800)) - 32;
                base_y = int'($urandom_range(0, 800)) - 32;
                add_load(base_x + $urandom_range(0, 96), base_y + $urandom_range(0, 96),
                         $urandom,
                         base_x + $urandom_range(0, 96), base_y + $urandom_range(0, 96),
                         $urandom,
                         base_x + $urandom_range(0, 96), base_y + $urandom_range(0, 96),
                         $urandom);
            end
            n++;
            if ($urandom_range(0, 3) == 0) begin
                n += 2;
                add_steps(2);
            end
            else begin
                add_steps($urandom_range(1, 30));
                n += 15;
            end
        end
    endtask

    logic [8:0] widths  [5] = '{9'd0, 9'd40, 9'd511, 9'd1, 9'd256};
    logic [8:0] heights [5] = '{9'd511, 9'd23, 9'd0, 9'd256, 9'd256};

    initial
    begin
        for (int i = 0; i < MAX_WIDTH * MAX_HEIGHT; i++)
            zbuf[i] = DEPTH_MIN;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_reg(CFG_FRAME_WIDTH, 9'd256);
        write_reg(CFG_FRAME_HEIGHT, 9'd256);
        // directed: no triangle, depth test pass/fail, degenerate, empty box,
        // extreme vertices with a reload mid-scan
        add_steps(1);
        add_load(0, 0, 100, 16, 0, 100, 0, 16, 100);
        add_steps(4);
        add_load(0, 0, 50, 16, 0, 50, 0, 16, 50);
        add_steps(4);
        add_load(0, 0, 32767, 16, 0, 32767, 0, 16, 32767);
        add_steps(4);
        add_load(0, 0, 0, 16, 16, 0, 32, 32, 0);
        add_steps(3);
        add_load(-40, -20, 0, -100, -5, 0, -17, -90, 0);
        add_steps(1);
        add_load(-32768, -32768, -32768, 32767, -32768, 32767, -32768, 32767, 0);
        add_steps(3);
        add_load(5, 7, -300, 40, 3, 700, 20, 50, 12);
        add_steps(2);
        random_triangles(200);
        drain();

        for (int p = 0; p < 5; p++)
        begin
            write_reg(CFG_FRAME_WIDTH, widths[p]);
            write_reg(CFG_FRAME_HEIGHT, heights[p]);
            if (p == 4) no_gaps = 1;
            random_triangles(180);
            drain();
        end

        if (!failed)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

FILE: filelist.f
design/trd_pkg.sv
design/trd_front.sv
design/trd_queue.sv
design/trd_back.sv
design/triangle_raster_depth_test.sv
design/trd_checker.sv
bench/tb_triangle_raster_depth_test.sv
